// ----- src/assert_macros.svh -----
// assertion macros used by the port-level checker, hsvc_checker.sv
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is low
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// clocked assertion that is also checked during reset
`define ASSERT_CLK_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/hsvc_pkg.sv -----
// constants, types and packing widths for the hsv to rgb converter
// no dependencies; used by every module of the block
package hsvc_pkg;

    localparam int FRAC_BITS     = 8;
    localparam int HUE_FRAC_BITS = 4;
    localparam int HUE_W         = 16;
    localparam int CH_W          = 9;
    localparam int ONE           = 1 << FRAC_BITS;
    localparam int SECTORS       = 6;

    // one 60 degree sector in hue units
    localparam int SECTOR_W  = 60 << HUE_FRAC_BITS;
    localparam int SW_W      = $clog2(SECTOR_W);
    localparam int K_MAX     = ((1 << HUE_W) - 1) / SECTOR_W;
    localparam int K_W       = $clog2(K_MAX + 1);
    localparam int NUM_W     = SW_W + FRAC_BITS;

    // reciprocal of the sector width, estimate is low by at most one
    localparam int DIV_SHIFT = (HUE_W > NUM_W) ? HUE_W : NUM_W;
    localparam int DIV_RECIP = (1 << DIV_SHIFT) / SECTOR_W;
    localparam int RECIP_W   = $clog2(DIV_RECIP + 1);

    // reciprocal of the sector count for the mod 6 step
    localparam int SEC_RECIP = (1 << K_W) / SECTORS;
    localparam int SEC_RW    = $clog2(SEC_RECIP + 1);
    localparam int SEC_W     = 3;

    localparam int S_TDATA_W = ((HUE_W + 2 * CH_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((3 * CH_W + 7) / 8) * 8;

    typedef enum logic [SEC_W-1:0] {
        SEC_RED     = 3'd0,
        SEC_YELLOW  = 3'd1,
        SEC_GREEN   = 3'd2,
        SEC_CYAN    = 3'd3,
        SEC_BLUE    = 3'd4,
        SEC_MAGENTA = 3'd5
    } hsvc_sector_t;

    typedef struct packed {
        hsvc_sector_t          sector;
        logic [FRAC_BITS-1:0]  frac;
        logic [CH_W-1:0]       sat;
        logic [CH_W-1:0]       val;
    } hsvc_split_t;

    typedef struct packed {
        logic [CH_W-1:0] blue;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] red;
    } hsvc_rgb_t;

endpackage

// ----- src/hsvc_div.sv -----
// hue split stages: clamp, sector index and fraction by reciprocal multiply
// depends on hsvc_pkg
module hsvc_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [hsvc_pkg::HUE_W-1:0]    in_hue,
    input  logic [hsvc_pkg::CH_W-1:0]     in_sat,
    input  logic [hsvc_pkg::CH_W-1:0]     in_val,
    output logic                          out_valid,
    input  logic                          out_ready,
    output hsvc_pkg::hsvc_split_t         out_data
);
    import hsvc_pkg::*;

    localparam int KP_W = HUE_W + RECIP_W;
    localparam int FP_W = NUM_W + RECIP_W;
    localparam int SP_W = K_W + SEC_RW;

    // stage 1
    logic                vld1_reg;
    logic [HUE_W-1:0]    hue1_reg;
    logic [CH_W-1:0]     sat1_reg, val1_reg;
    logic [KP_W-1:0]     kprod1_reg;
    // stage 2
    logic                vld2_reg;
    logic [K_W-1:0]      k2_reg;
    logic [SW_W-1:0]     rem2_reg;
    logic [CH_W-1:0]     sat2_reg, val2_reg;
    // stage 3
    logic                vld3_reg;
    logic [K_W-1:0]      k3_reg;
    logic [NUM_W-1:0]    num3_reg;
    logic [FP_W-1:0]     fprod3_reg;
    logic [SP_W-1:0]     sprod3_reg;
    logic [CH_W-1:0]     sat3_reg, val3_reg;
    // stage 4
    logic                vld4_reg;
    hsvc_split_t         out4_reg;

    logic rdy1, rdy2, rdy3, rdy4;

    logic [CH_W-1:0]     sat_cl, val_cl;
    logic [KP_W-1:0]     kprod;
    logic [K_W-1:0]      k_est, k_next;
    logic [HUE_W-1:0]    rem_est;
    logic [SW_W-1:0]     rem_next;
    logic [NUM_W-1:0]    num;
    logic [FP_W-1:0]     fprod;
    logic [SP_W-1:0]     sprod;
    logic [FRAC_BITS-1:0] f_est, f_next;
    logic [NUM_W-1:0]    f_rem;
    logic [K_W-1:0]      k6, sec_est;
    logic [SEC_W-1:0]    sec_next;

    assign rdy4     = !vld4_reg || out_ready;
    assign rdy3     = !vld3_reg || rdy4;
    assign rdy2     = !vld2_reg || rdy3;
    assign rdy1     = !vld1_reg || rdy2;
    assign in_ready = rdy1;

    always_comb begin
        sat_cl = (in_sat > CH_W'(ONE)) ? CH_W'(ONE) : in_sat;
        val_cl = (in_val > CH_W'(ONE)) ? CH_W'(ONE) : in_val;
        kprod  = KP_W'(in_hue) * KP_W'(DIV_RECIP);

        // quotient estimate is never high and at most one low
        k_est   = K_W'(kprod1_reg >> DIV_SHIFT);
        rem_est = hue1_reg - HUE_W'(k_est) * HUE_W'(SECTOR_W);
        if (rem_est >= HUE_W'(SECTOR_W)) begin
            k_next   = k_est + K_W'(1);
            rem_next = SW_W'(rem_est - HUE_W'(SECTOR_W));
        end else begin
            k_next   = k_est;
            rem_next = SW_W'(rem_est);
        end

        num   = {rem2_reg, FRAC_BITS'(0)};
        fprod = FP_W'(num) * FP_W'(DIV_RECIP);
        sprod = SP_W'(k2_reg) * SP_W'(SEC_RECIP);

        f_est = FRAC_BITS'(fprod3_reg >> DIV_SHIFT);
        f_rem = num3_reg - NUM_W'(f_est) * NUM_W'(SECTOR_W);
        f_next = (f_rem >= NUM_W'(SECTOR_W)) ? f_est + FRAC_BITS'(1) : f_est;

        // sector is the whole-turn sector count mod 6
        k6      = K_W'(sprod3_reg >> K_W);
        sec_est = k3_reg - K_W'(k6 * K_W'(SECTORS));
        if (sec_est >= K_W'(SECTORS)) begin
            sec_next = SEC_W'(sec_est - K_W'(SECTORS));
        end else begin
            sec_next = SEC_W'(sec_est);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
            vld4_reg <= 1'b0;
        end else begin
            if (rdy1) vld1_reg <= in_valid;
            if (rdy2) vld2_reg <= vld1_reg;
            if (rdy3) vld3_reg <= vld2_reg;
            if (rdy4) vld4_reg <= vld3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) begin
            hue1_reg   <= in_hue;
            sat1_reg   <= sat_cl;
            val1_reg   <= val_cl;
            kprod1_reg <= kprod;
        end
        if (rdy2 && vld1_reg) begin
            k2_reg   <= k_next;
            rem2_reg <= rem_next;
            sat2_reg <= sat1_reg;
            val2_reg <= val1_reg;
        end
        if (rdy3 && vld2_reg) begin
            k3_reg     <= k2_reg;
            num3_reg   <= num;
            fprod3_reg <= fprod;
            sprod3_reg <= sprod;
            sat3_reg   <= sat2_reg;
            val3_reg   <= val2_reg;
        end
        if (rdy4 && vld3_reg) begin
            out4_reg.sector <= hsvc_sector_t'(sec_next);
            out4_reg.frac   <= f_next;
            out4_reg.sat    <= sat3_reg;
            out4_reg.val    <= val3_reg;
        end
    end

    assign out_valid = vld4_reg;
    assign out_data  = out4_reg;

endmodule

// ----- src/hsvc_mix.sv -----
// p, q, t products and channel selection by sector
// depends on hsvc_pkg
module hsvc_mix (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  hsvc_pkg::hsvc_split_t  in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output hsvc_pkg::hsvc_rgb_t    out_data
);
    import hsvc_pkg::*;

    localparam int PR_W = 2 * CH_W;

    // stage 5
    logic                vld5_reg;
    logic [CH_W-1:0]     one_s5_reg, one_sf5_reg, one_snf5_reg, val5_reg;
    hsvc_sector_t        sec5_reg;
    logic                grey5_reg;
    // stage 6
    logic                vld6_reg;
    hsvc_rgb_t           rgb6_reg;

    logic rdy5, rdy6;

    logic [CH_W-1:0] one_f, sf, snf;
    logic [CH_W-1:0] p, q, t;
    hsvc_rgb_t       rgb_next;

    assign rdy6     = !vld6_reg || out_ready;
    assign rdy5     = !vld5_reg || rdy6;
    assign in_ready = rdy5;

    always_comb begin
        one_f = CH_W'(ONE) - CH_W'(in_data.frac);
        sf    = CH_W'((PR_W'(in_data.sat) * PR_W'(in_data.frac)) >> FRAC_BITS);
        snf   = CH_W'((PR_W'(in_data.sat) * PR_W'(one_f)) >> FRAC_BITS);

        p = CH_W'((PR_W'(val5_reg) * PR_W'(one_s5_reg)) >> FRAC_BITS);
        q = CH_W'((PR_W'(val5_reg) * PR_W'(one_sf5_reg)) >> FRAC_BITS);
        t = CH_W'((PR_W'(val5_reg) * PR_W'(one_snf5_reg)) >> FRAC_BITS);

        rgb_next = '{blue: val5_reg, green: val5_reg, red: val5_reg};
        if (!grey5_reg) begin
            case (sec5_reg)
                SEC_RED:     rgb_next = '{blue: p,        green: t,        red: val5_reg};
                SEC_YELLOW:  rgb_next = '{blue: p,        green: val5_reg, red: q};
                SEC_GREEN:   rgb_next = '{blue: t,        green: val5_reg, red: p};
                SEC_CYAN:    rgb_next = '{blue: val5_reg, green: q,        red: p};
                SEC_BLUE:    rgb_next = '{blue: val5_reg, green: p,        red: t};
                default:     rgb_next = '{blue: q,        green: p,        red: val5_reg};
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld5_reg <= 1'b0;
            vld6_reg <= 1'b0;
        end else begin
            if (rdy5) vld5_reg <= in_valid;
            if (rdy6) vld6_reg <= vld5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy5 && in_valid) begin
            one_s5_reg   <= CH_W'(ONE) - in_data.sat;
            one_sf5_reg  <= CH_W'(ONE) - sf;
            one_snf5_reg <= CH_W'(ONE) - snf;
            val5_reg     <= in_data.val;
            sec5_reg     <= in_data.sector;
            grey5_reg    <= (in_data.sat == '0);
        end
        if (rdy6 && vld5_reg) begin
            rgb6_reg <= rgb_next;
        end
    end

    assign out_valid = vld6_reg;
    assign out_data  = rgb6_reg;

endmodule

// ----- src/hsv_to_rgb_convert.sv -----
// top level of the hsv to rgb converter: stream ports and tdata packing
// depends on hsvc_pkg, hsvc_div, hsvc_mix
//
//  channel | dir | ports                      | tdata fields (low bit up)
//  --------+-----+----------------------------+---------------------------------------
//  s_      | in  | s_tvalid s_tready s_tdata  | hue[15:0] saturation[24:16] brightness[33:25]
//  m_      | out | m_tvalid m_tready m_tdata  | red[8:0] green[17:9] blue[26:18]
//
// one transaction per clock sustained while m_tready stays high; six register stages,
// and a result reaches the output register once it has passed through all of them
// stages: hue product, sector correction, fraction product, fraction and mod 6 correction,
// inner products, outer products and channel select
// every stage has its own valid bit and loads when it is empty or its successor moves,
// so bubbles are squeezed out and input keeps flowing while a result waits on m_tready
// until all six stages hold data
// synchronous active-low reset clears the valid bits only
module hsv_to_rgb_convert (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // hue[15:0], saturation[24:16], brightness[33:25], zero pad to 40 bits
    input  logic [hsvc_pkg::S_TDATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // red[8:0], green[17:9], blue[26:18], zero pad to 32 bits
    output logic [hsvc_pkg::M_TDATA_W-1:0]  m_tdata
);
    import hsvc_pkg::*;

    logic            split_valid, split_ready;
    hsvc_split_t     split_data;
    hsvc_rgb_t       rgb;

    hsvc_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_hue    (s_tdata[HUE_W-1:0]),
        .in_sat    (s_tdata[HUE_W+CH_W-1:HUE_W]),
        .in_val    (s_tdata[HUE_W+2*CH_W-1:HUE_W+CH_W]),
        .out_valid (split_valid),
        .out_ready (split_ready),
        .out_data  (split_data)
    );

    hsvc_mix u_mix (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (split_valid),
        .in_ready  (split_ready),
        .in_data   (split_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (rgb)
    );

    assign m_tdata = M_TDATA_W'({rgb.blue, rgb.green, rgb.red});

endmodule

// ----- src/hsvc_checker.sv -----
// port-level checks for the hsv to rgb converter, bound to the top level
// depends on hsvc_pkg and assert_macros.svh
`include "assert_macros.svh"

module hsvc_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [hsvc_pkg::S_TDATA_W-1:0]  s_tdata,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [hsvc_pkg::M_TDATA_W-1:0]  m_tdata
);
    import hsvc_pkg::*;

    // reset empties the pipeline
    `ASSERT_CLK_ALWAYS(a_reset_empty, aclk, !aresetn |=> !m_tvalid, "output valid after reset")

    // an empty output stage means every stage can load
    `ASSERT_CLK(a_ready_when_empty, aclk, aresetn, !m_tvalid |-> s_tready, "input stalled with empty output")

    // channels never exceed 1.0 and the pad bits stay zero
    `ASSERT_CLK(a_range, aclk, aresetn, m_tvalid |-> (m_tdata[CH_W-1:0] <= CH_W'(ONE)) && (m_tdata[2*CH_W-1:CH_W] <= CH_W'(ONE)) && (m_tdata[3*CH_W-1:2*CH_W] <= CH_W'(ONE)) && (m_tdata[M_TDATA_W-1:3*CH_W] == '0), "channel out of range")

    `ASSERT_CLK(a_hold_valid, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid, "result dropped while stalled")

    `ASSERT_CLK(a_hold_data, aclk, aresetn, m_tvalid && !m_tready |=> $stable(m_tdata), "result changed while stalled")

endmodule

bind hsv_to_rgb_convert hsvc_checker u_hsvc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
